[hw/rtl/rvw_pkg.sv]
// shared constants, command codes and handshake structs for the realized volatility block
package rvw_pkg;

   localparam int MAX_DAYS_DEF = 64;

   localparam logic [6:0]  WINDOW_RESET = 7'd30;
   localparam logic [6:0]  COUNT_CAP    = 7'd127;
   localparam logic [27:0] LN2_Q28      = 28'hB172180;
   localparam logic [10:0] ANNUAL_SCALE = 11'd1460;
   localparam logic [63:0] SCALE_LIMIT  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1460;

   // iteration counts, last step index
   localparam int LOG_LAST  = 29;
   localparam int DIV_LAST  = 63;
   localparam int SQRT_LAST = 31;

   // result error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_COUNT = 2'd1;
   localparam logic [1:0] ERR_ZERO  = 2'd2;

   // datapath operations
   localparam logic [4:0] OP_NONE      = 5'd0;
   localparam logic [4:0] OP_LOAD      = 5'd1;
   localparam logic [4:0] OP_LOG       = 5'd2;
   localparam logic [4:0] OP_RMUL      = 5'd3;
   localparam logic [4:0] OP_STORE     = 5'd4;
   localparam logic [4:0] OP_MEAN_INIT = 5'd5;
   localparam logic [4:0] OP_DIV_STEP  = 5'd6;
   localparam logic [4:0] OP_MEAN      = 5'd7;
   localparam logic [4:0] OP_RD        = 5'd8;
   localparam logic [4:0] OP_DIFF      = 5'd9;
   localparam logic [4:0] OP_SQ        = 5'd10;
   localparam logic [4:0] OP_ACC       = 5'd11;
   localparam logic [4:0] OP_VAR_INIT  = 5'd12;
   localparam logic [4:0] OP_SCALE1    = 5'd13;
   localparam logic [4:0] OP_SCALE2    = 5'd14;
   localparam logic [4:0] OP_SQRT      = 5'd15;
   localparam logic [4:0] OP_EMIT      = 5'd16;

   typedef struct packed {
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic       last;
      logic [1:0] err;
      logic [6:0] span;
   } sts_type;

endpackage

[hw/rtl/rvw_ctrl.sv]
// sequencing state machine for the realized volatility block
module rvw_ctrl
   import rvw_pkg::*;
#(
   parameter int CW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  sts_type       sts,
   output cmd_type       cmd,
   output logic [CW-1:0] idx
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_LOG    = 5'd1;
   localparam logic [4:0] S_RMUL   = 5'd2;
   localparam logic [4:0] S_STORE  = 5'd3;
   localparam logic [4:0] S_CHECK  = 5'd4;
   localparam logic [4:0] S_DIVM   = 5'd5;
   localparam logic [4:0] S_MEAN   = 5'd6;
   localparam logic [4:0] S_RD     = 5'd7;
   localparam logic [4:0] S_DIFF   = 5'd8;
   localparam logic [4:0] S_SQ     = 5'd9;
   localparam logic [4:0] S_ACC    = 5'd10;
   localparam logic [4:0] S_VINIT  = 5'd11;
   localparam logic [4:0] S_DIVV   = 5'd12;
   localparam logic [4:0] S_SCALE1 = 5'd13;
   localparam logic [4:0] S_SCALE2 = 5'd14;
   localparam logic [4:0] S_SQRT   = 5'd15;
   localparam logic [4:0] S_EMIT   = 5'd16;

   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] elem_last;

   assign elem_last = CW'(sts.span) - CW'(1);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign idx       = step_ff;

   // next state and command
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               step_in  = '0;
               state_in = S_LOG;
            end
         end
         S_LOG: begin
            cmd.op = OP_LOG;
            if (step_ff == CW'(LOG_LAST)) begin
               step_in  = '0;
               state_in = S_RMUL;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         S_RMUL: begin
            cmd.op   = OP_RMUL;
            state_in = S_STORE;
         end
         S_STORE: begin
            cmd.op   = OP_STORE;
            state_in = sts.last ? S_CHECK : S_IDLE;
         end
         S_CHECK: begin
            if (sts.err != ERR_NONE) begin
               state_in = S_EMIT;
            end else begin
               cmd.op   = OP_MEAN_INIT;
               step_in  = '0;
               state_in = S_DIVM;
            end
         end
         S_DIVM: begin
            cmd.op = OP_DIV_STEP;
            if (step_ff == CW'(DIV_LAST)) begin
               step_in  = '0;
               state_in = S_MEAN;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         S_MEAN: begin
            cmd.op   = OP_MEAN;
            step_in  = '0;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.op   = OP_RD;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op   = OP_SQ;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (step_ff == elem_last) begin
               step_in  = '0;
               state_in = S_VINIT;
            end else begin
               step_in  = step_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_VINIT: begin
            cmd.op   = OP_VAR_INIT;
            step_in  = '0;
            state_in = S_DIVV;
         end
         S_DIVV: begin
            cmd.op = OP_DIV_STEP;
            if (step_ff == CW'(DIV_LAST)) begin
               step_in  = '0;
               state_in = S_SCALE1;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         S_SCALE1: begin
            cmd.op   = OP_SCALE1;
            state_in = S_SCALE2;
         end
         S_SCALE2: begin
            cmd.op   = OP_SCALE2;
            step_in  = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT;
            if (step_ff == CW'(SQRT_LAST)) begin
               step_in  = '0;
               state_in = S_EMIT;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         S_EMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/rvw_datapath.sv]
// log, return store, divider, square root and result registers
module rvw_datapath
   import rvw_pkg::*;
#(
   parameter int MAX_DAYS = MAX_DAYS_DEF,
   parameter int CW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [31:0]   req_price,
   input  logic          req_last,
   input  logic          csr_valid,
   input  logic [6:0]    csr_span,
   input  cmd_type       cmd,
   input  logic [CW-1:0] idx,
   output sts_type       sts,
   output logic [31:0]   rsp_volatility,
   output logic [1:0]    rsp_error
);

   localparam int AW = (MAX_DAYS > 2) ? $clog2(MAX_DAYS) : 1;

   // return store
   logic signed [31:0] mem [MAX_DAYS];
   logic signed [31:0] rd_ff;

   logic [6:0]  span_ff;
   logic [31:0] price_ff;
   logic        last_ff;
   logic [31:0] y_ff;
   logic [29:0] frac_ff;
   logic [4:0]  k_ff;
   logic [34:0] prev_log_ff;
   logic        prev_nz_ff;
   logic [6:0]  count_ff;
   logic signed [39:0] sum_ff;
   logic        bad_ff;
   logic [62:0] prod_ff;
   logic        rneg_ff;
   logic [63:0] dd_ff;
   logic [6:0]  rem_ff;
   logic [6:0]  dvs_ff;
   logic        sneg_ff;
   logic signed [39:0] mean_ff;
   logic [31:0] ad_ff;
   logic [63:0] sq_ff;
   logic [63:0] sumsq_ff;
   logic        sat_ff;
   logic [42:0] plo_ff, phi_ff;
   logic [63:0] v_ff, root_ff, bit_ff;
   logic [31:0] vol_ff;
   logic [1:0]  err_ff;

   // leading one and normalize
   logic [4:0]  lead_w;
   logic [31:0] norm_w;
   always_comb begin
      lead_w = '0;
      for (int i = 0; i < 32; i++) begin
         if (req_price[i]) lead_w = 5'(i);
      end
   end
   assign norm_w = req_price << (5'd31 - lead_w);

   // one squaring step of the log fraction
   logic [63:0] ysq_w;
   logic [32:0] ys_w;
   assign ysq_w = y_ff * y_ff;
   assign ys_w  = ysq_w[63:31];

   // log difference times ln2
   logic [34:0] cur_log_w, lmag_w;
   logic        lneg_w;
   logic [62:0] lprod_w;
   assign cur_log_w = {k_ff, frac_ff};
   assign lneg_w    = prev_log_ff > cur_log_w;
   assign lmag_w    = lneg_w ? (prev_log_ff - cur_log_w) : (cur_log_w - prev_log_ff);
   assign lprod_w   = lmag_w * LN2_Q28;

   // round half away and saturate the return
   logic [63:0] rsum_w;
   logic [32:0] q_w;
   logic signed [31:0] rsat_w, ret_w;
   assign rsum_w = {1'b0, prod_ff} + 64'h4000_0000;
   assign q_w    = rsum_w[63:31];
   always_comb begin
      if (rneg_ff) begin
         rsat_w = (q_w >= 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(q_w[31:0]);
      end else begin
         rsat_w = (q_w > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_w[31:0]);
      end
   end
   assign ret_w = (count_ff != 7'd0 && price_ff != 32'd0 && prev_nz_ff) ? rsat_w : 32'sd0;

   // store index
   logic [6:0]  widx_w;
   logic        wen_w;
   assign widx_w = count_ff - 7'd1;
   assign wen_w  = (cmd.op == OP_STORE) && (count_ff != 7'd0) && (32'(widx_w) < MAX_DAYS);

   // window check
   logic [1:0] err_w;
   always_comb begin
      if (span_ff < 7'd2 || 32'(span_ff) > MAX_DAYS ||
          count_ff >= COUNT_CAP || {1'b0, count_ff} != ({1'b0, span_ff} + 8'd1)) begin
         err_w = ERR_COUNT;
      end else if (bad_ff) begin
         err_w = ERR_ZERO;
      end else begin
         err_w = ERR_NONE;
      end
   end
   assign sts.last = last_ff;
   assign sts.err  = err_w;
   assign sts.span = span_ff;

   // divider step
   logic [7:0] dtry_w;
   logic       dfit_w;
   assign dtry_w = {rem_ff, dd_ff[63]};
   assign dfit_w = dtry_w >= {1'b0, dvs_ff};

   // mean dividend
   logic [39:0] smag_w;
   assign smag_w = sum_ff[39] ? 40'(-sum_ff) : 40'(sum_ff);

   // deviation magnitude
   logic signed [40:0] dev_w;
   logic [40:0] dabs_w;
   assign dev_w  = {{9{rd_ff[31]}}, rd_ff} - {mean_ff[39], mean_ff};
   assign dabs_w = dev_w[40] ? 41'(-dev_w) : 41'(dev_w);

   // saturating square sum
   logic [64:0] acc_w;
   assign acc_w = {1'b0, sumsq_ff} + {1'b0, sq_ff};

   // square root step
   logic [63:0] trial_w;
   assign trial_w = root_ff + bit_ff;

   // final value
   logic [31:0] vol_w;
   assign vol_w = (err_w != ERR_NONE) ? 32'd0 : (sat_ff ? 32'hFFFF_FFFF : root_ff[31:0]);

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wen_w) mem[AW'(32'(widx_w))] <= ret_w;
      if (cmd.op == OP_RD) rd_ff <= mem[AW'(idx)];
   end

   // window control state
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff    <= WINDOW_RESET;
         prev_nz_ff <= 1'b0;
         count_ff   <= '0;
         sum_ff     <= '0;
         bad_ff     <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         if (csr_valid) span_ff <= csr_span;
         case (cmd.op)
            OP_LOAD: last_ff <= req_last;
            OP_STORE: begin
               prev_nz_ff <= price_ff != 32'd0;
               if (price_ff == 32'd0) bad_ff <= 1'b1;
               if (count_ff < COUNT_CAP) count_ff <= count_ff + 7'd1;
               if (wen_w) sum_ff <= sum_ff + {{8{ret_w[31]}}, ret_w};
            end
            OP_EMIT: begin
               prev_nz_ff <= 1'b0;
               count_ff   <= '0;
               sum_ff     <= '0;
               bad_ff     <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            price_ff <= req_price;
            y_ff     <= norm_w;
            k_ff     <= lead_w;
            frac_ff  <= '0;
         end
         OP_LOG: begin
            if (ys_w[32]) begin
               y_ff    <= ys_w[32:1];
               frac_ff <= {frac_ff[28:0], 1'b1};
            end else begin
               y_ff    <= ys_w[31:0];
               frac_ff <= {frac_ff[28:0], 1'b0};
            end
         end
         OP_RMUL: begin
            prod_ff <= lprod_w;
            rneg_ff <= lneg_w;
         end
         OP_STORE: prev_log_ff <= cur_log_w;
         OP_MEAN_INIT: begin
            dd_ff    <= 64'(smag_w) + 64'(span_ff >> 1);
            rem_ff   <= '0;
            dvs_ff   <= span_ff;
            sneg_ff  <= sum_ff[39];
            sumsq_ff <= '0;
         end
         OP_DIV_STEP: begin
            dd_ff  <= {dd_ff[62:0], dfit_w};
            rem_ff <= dfit_w ? 7'(dtry_w - {1'b0, dvs_ff}) : dtry_w[6:0];
         end
         OP_MEAN: mean_ff <= sneg_ff ? -$signed(dd_ff[39:0]) : $signed(dd_ff[39:0]);
         OP_DIFF: ad_ff <= dabs_w[31:0];
         OP_SQ: sq_ff <= ad_ff * ad_ff;
         OP_ACC: sumsq_ff <= acc_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_w[63:0];
         OP_VAR_INIT: begin
            dd_ff  <= sumsq_ff;
            rem_ff <= '0;
            dvs_ff <= span_ff - 7'd1;
         end
         OP_SCALE1: begin
            sat_ff <= dd_ff > SCALE_LIMIT;
            plo_ff <= dd_ff[31:0] * ANNUAL_SCALE;
            phi_ff <= dd_ff[63:32] * ANNUAL_SCALE;
         end
         OP_SCALE2: begin
            v_ff    <= {phi_ff[31:0], 32'd0} + {21'd0, plo_ff};
            root_ff <= '0;
            bit_ff  <= 64'h4000_0000_0000_0000;
         end
         OP_SQRT: begin
            if (v_ff >= trial_w) begin
               v_ff    <= v_ff - trial_w;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_EMIT: begin
            vol_ff <= vol_w;
            err_ff <= err_w;
         end
         default: begin
         end
      endcase
   end

   assign rsp_volatility = vol_ff;
   assign rsp_error      = err_ff;

endmodule

[hw/rtl/realized_volatility_window_top.sv]
// Annualized realized volatility: one price per item, result on the closing item.
// Each price runs 30 squaring steps for the log fraction, then multiply and store.
// Closing price adds two 64-step dividers, an n-element sum-of-squares pass (read, difference,
// square and accumulate for each stored return), and a 32-step square root; result sits in an output register.
// Error windows skip the arithmetic and go straight to the result.
// Synchronous active-high reset clears the window state; the window span resets to 30 days.
module realized_volatility_window_top
   import rvw_pkg::*;
#(
   parameter int MAX_DAYS = MAX_DAYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_price,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_volatility,
   output logic [1:0]  rsp_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_span
);

   localparam int CW = ($clog2(MAX_DAYS) > 7) ? $clog2(MAX_DAYS) : 7;

   cmd_type       cmd;
   sts_type       sts;
   logic [CW-1:0] idx;

   assign csr_ready = 1'b1;

   // sequencer
   rvw_ctrl #(
      .CW(CW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts(sts),
      .cmd(cmd),
      .idx(idx)
   );

   // arithmetic and storage
   rvw_datapath #(
      .MAX_DAYS(MAX_DAYS),
      .CW(CW)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_price(req_price),
      .req_last(req_last),
      .csr_valid(csr_valid),
      .csr_span(csr_span),
      .cmd(cmd),
      .idx(idx),
      .sts(sts),
      .rsp_volatility(rsp_volatility),
      .rsp_error(rsp_error)
   );

`ifndef ASSERT_OFF
   // an error result carries zero volatility
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != ERR_NONE |-> rsp_volatility == 32'd0)
      else $error("error result with nonzero volatility");

   // only defined error codes leave the block
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error <= ERR_ZERO)
      else $error("undefined error code");

   // an accepted beat keeps the input closed for the log iterations
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input reopened before the price was processed");
`endif

endmodule
